// ----- hdl/wfba_pkg.sv -----
// types and constants shared by the worst-fit block allocator
package wfba_pkg;

  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SLOT_W-1:0]   slot_index;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   block_number;
    logic [AMOUNT_W-1:0] block_size;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } wfba_state_e;

endpackage

// ----- hdl/worst_fit_block_allocator_core.sv -----
// worst-fit block allocator top level: size table scan and grant control
// a load beat writes one size table entry and yields no result; a request beat scans
// the table and posts its result: one table read per entry, a last compare, the end of
// the scan and the post; no new beat is taken until the result is posted, and a stalled
// earlier result holds the post off
// reset clears all used flags, block_count and the control state; no size table clearing
module worst_fit_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wfba_pkg::COUNT_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wfba_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wfba_pkg::out_item_t         out_data_o
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (SIZE_BITS > wfba_pkg::AMOUNT_W) ? SIZE_BITS
                                                                   : wfba_pkg::AMOUNT_W;

  wfba_pkg::wfba_state_e state_q, state_d;

  logic [wfba_pkg::COUNT_W-1:0]  block_count_q;
  logic [NUM_BLOCKS-1:0]         used_q, used_d;
  logic [CNT_W-1:0]              limit_q, limit_d;
  logic [CNT_W-1:0]              rd_cnt_q, rd_cnt_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]              cmp_idx_q, cmp_idx_d;
  logic                          found_q, found_d;
  logic [IDX_W-1:0]              best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0]          best_size_q, best_size_d;
  logic [wfba_pkg::AMOUNT_W-1:0] amount_q, amount_d;
  logic                          out_valid_q, out_valid_d;
  wfba_pkg::out_item_t           out_data_q, out_data_d;

  logic                 in_beat;
  logic                 out_free;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 fits;

  wfba_size_ram #(
    .DEPTH  (NUM_BLOCKS),
    .ADDR_W (IDX_W),
    .DATA_W (SIZE_BITS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != wfba_pkg::ST_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign ram_waddr = IDX_W'(in_data_i.slot_index);
  assign ram_wdata = SIZE_BITS'(in_data_i.amount);
  assign ram_we    = in_beat && (in_data_i.func == wfba_pkg::FUNC_LOAD) &&
                     (32'(in_data_i.slot_index) < 32'(NUM_BLOCKS));
  assign ram_raddr = rd_cnt_q[IDX_W-1:0];
  assign ram_re    = (state_q == wfba_pkg::ST_SCAN) && (rd_cnt_q < limit_q);

  // candidate in the compare stage: free and large enough
  assign fits = cmp_vld_q && !used_q[cmp_idx_q] &&
                (CMP_W'(ram_rdata) >= CMP_W'(amount_q));

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    limit_d     = limit_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    amount_d    = amount_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      wfba_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_data_i.func == wfba_pkg::FUNC_LOAD) begin
            if (ram_we) begin
              used_d[ram_waddr] = 1'b0;
            end
          end else begin
            if (32'(block_count_q) > 32'(NUM_BLOCKS)) begin
              limit_d = CNT_W'(NUM_BLOCKS);
            end else begin
              limit_d = CNT_W'(block_count_q);
            end
            amount_d = in_data_i.amount;
            rd_cnt_d = '0;
            found_d  = 1'b0;
            state_d  = wfba_pkg::ST_SCAN;
          end
        end
      end
      wfba_pkg::ST_SCAN: begin
        if (ram_re) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IDX_W-1:0];
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
        end else if (!cmp_vld_q) begin
          state_d = wfba_pkg::ST_DONE;
        end
        // strict greater keeps the lowest index on equal sizes
        if (fits && (!found_q || (ram_rdata > best_size_q))) begin
          found_d     = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_size_d = ram_rdata;
        end
      end
      wfba_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            used_d[best_idx_q]      = 1'b1;
            out_data_d.granted      = 1'b1;
            out_data_d.block_number = wfba_pkg::SLOT_W'(best_idx_q);
            out_data_d.block_size   = wfba_pkg::AMOUNT_W'(best_size_q);
          end else begin
            out_data_d.granted      = 1'b0;
            out_data_d.block_number = '0;
            out_data_d.block_size   = '0;
          end
          state_d = wfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wfba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= wfba_pkg::ST_IDLE;
      block_count_q <= '0;
      used_q        <= '0;
      cmp_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        block_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q     <= limit_d;
    rd_cnt_q    <= rd_cnt_d;
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    amount_q    <= amount_d;
    out_data_q  <= out_data_d;
  end

endmodule

// ----- hdl/wfba_size_ram.sv -----
// block size table: one write port, one registered read port
module wfba_size_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
